>>> hdl/eacc_pkg.sv
// Shared types, constants and gear tables for the assist current command block.
`default_nettype none
package eacc_pkg;

    localparam int unsigned DUTY_FLOOR_Q15      = 655;
    localparam int unsigned TAPER_WINDOW        = 200;
    localparam int unsigned PHASE_RATIO_MUL     = 100;
    localparam int unsigned RAMP_SLOW_MA        = 4000;
    localparam int unsigned RAMP_FAST_MA        = 8000;
    localparam int unsigned UNITY_Q16           = 65536;
    localparam int unsigned MAX_SPEED_RESET     = 2500;

    // floor(diff * 65536 / 200) = (diff * TAPER_RECIP) >> TAPER_RECIP_SHIFT, diff < 200
    localparam int unsigned TAPER_RECIP         = 2684355;
    localparam int unsigned TAPER_RECIP_SHIFT   = 13;
    // floor(x / 33) = (x * PHASE_RECIP) >> PHASE_RECIP_SHIFT, x < 2^22
    localparam int unsigned PHASE_RECIP         = 8134408;
    localparam int unsigned PHASE_RECIP_SHIFT   = 28;

    localparam int unsigned DIV_DIVIDEND_W      = 32;
    localparam int unsigned DIV_DIVISOR_W       = 16;
    localparam int unsigned DIV_CNT_W           = 4;

    typedef enum logic [1:0] {
        REG_MAX_SPEED   = 2'd0,
        REG_MOTOR_MAX   = 2'd1,
        REG_MOTOR_FALLBACK = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_PAS    = 2'd0,
        MODE_TORQUE = 2'd1,
        MODE_HYBRID = 2'd2
    } assist_source_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TAPER_FIXED,
        OP_TAPER_WIN,
        OP_DEMAND,
        OP_GEAR,
        OP_SCALE,
        OP_PHASE,
        OP_DIV_BLIM,
        OP_BLIM_Q,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAPER,
        ST_DEMAND,
        ST_GEAR,
        ST_SCALE,
        ST_PHASE,
        ST_BLIM,
        ST_BLIM_WAIT,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   div_start;
    } dp_cmd_t;

    typedef struct packed {
        logic taper_window;
        logic batt_pos;
        logic div_done;
        logic out_free;
    } dp_status_t;

    function automatic logic [15:0] gear_table(input logic mountain, input logic [7:0] gear);
        logic [15:0] ma;
        ma = 16'd0;
        if (mountain) begin
            case (gear)
                8'd0:    ma = 16'd0;
                8'd1:    ma = 16'd2500;
                8'd2:    ma = 16'd5000;
                8'd3:    ma = 16'd9000;
                8'd4:    ma = 16'd15000;
                8'd5:    ma = 16'd30000;
                default: ma = 16'd40000;
            endcase
        end else begin
            case (gear)
                8'd0:    ma = 16'd0;
                8'd1:    ma = 16'd2000;
                8'd2:    ma = 16'd3125;
                default: ma = 16'd5000;
            endcase
        end
        return ma;
    endfunction

endpackage
`default_nettype wire

>>> hdl/eacc_div.sv
// Restoring divider, two quotient bits per cycle.
`default_nettype none
module eacc_div
    import eacc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [DIV_DIVIDEND_W-1:0] dividend,
    input  wire logic [DIV_DIVISOR_W-1:0]  divisor,
    output logic                           done,
    output logic [DIV_DIVIDEND_W-1:0]      quotient
);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIV_DIVISOR_W:0]    rem_reg, rem_next;
    logic [DIV_DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIV_DIVISOR_W-1:0]  div_reg, div_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    always_comb begin
        logic [DIV_DIVISOR_W:0]    r;
        logic [DIV_DIVIDEND_W-1:0] q;
        r         = rem_reg;
        q         = quo_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        if (start) begin
            r         = '0;
            q         = dividend;
            div_next  = divisor;
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            for (int i = 0; i < 2; i++) begin
                r = {r[DIV_DIVISOR_W-1:0], q[DIV_DIVIDEND_W-1]};
                q = {q[DIV_DIVIDEND_W-2:0], 1'b0};
                if (r >= {1'b0, div_reg}) begin
                    r    = r - {1'b0, div_reg};
                    q[0] = 1'b1;
                end
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == {DIV_CNT_W{1'b1}}) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        rem_next = r;
        quo_next = q;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

>>> hdl/eacc_ctrl.sv
// Sequencer for one tick: taper, demand, phase target, duty limit, slew.
`default_nettype none
module eacc_ctrl
    import eacc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t stat,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.op        = OP_NONE;
        cmd.div_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_TAPER;
                end
            end
            ST_TAPER:
            begin
                if (stat.taper_window) begin
                    cmd.op = OP_TAPER_WIN;
                end else begin
                    cmd.op = OP_TAPER_FIXED;
                end
                state_next = ST_DEMAND;
            end
            ST_DEMAND:
            begin
                cmd.op     = OP_DEMAND;
                state_next = ST_GEAR;
            end
            ST_GEAR:
            begin
                cmd.op     = OP_GEAR;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.op     = OP_SCALE;
                state_next = ST_PHASE;
            end
            ST_PHASE:
            begin
                cmd.op     = OP_PHASE;
                state_next = stat.batt_pos ? ST_BLIM : ST_FINISH;
            end
            ST_BLIM:
            begin
                cmd.op        = OP_DIV_BLIM;
                cmd.div_start = 1'b1;
                state_next    = ST_BLIM_WAIT;
            end
            ST_BLIM_WAIT:
            begin
                if (stat.div_done) begin
                    cmd.op     = OP_BLIM_Q;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free) begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/eacc_dp.sv
// Datapath: config registers, working registers, divider and output register.
`default_nettype none
module eacc_dp
    import eacc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_cmd_t            cmd,
    output dp_status_t              stat,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [18:0]        cfg_data,
    input  wire logic [7:0]         gear,
    input  wire logic               mountain_mode,
    input  wire logic               drive_enable,
    input  wire logic [1:0]         assist_source,
    input  wire logic               pedaling,
    input  wire logic               torque_active,
    input  wire logic [15:0]        torque_level,
    input  wire logic [15:0]        speed_centikph,
    input  wire logic signed [15:0] duty_now,
    input  wire logic signed [18:0] battery_current_ma,
    input  wire logic               battery_current_valid,
    input  wire logic               stop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [17:0]             phase_current_ma
);

    // configuration
    logic [15:0]        vmax_reg;
    logic signed [18:0] mmax_reg;
    logic signed [18:0] mfb_reg;

    // latched item
    logic [15:0]        gear_ma_reg;
    logic               mtn_reg;
    logic [16:0]        support_reg;
    logic               fast_up_reg;
    logic [15:0]        speed_reg;
    logic [15:0]        duty_mag_reg;
    logic [18:0]        meas_reg;
    logic               stop_reg;

    // working registers
    logic [16:0]        taper_reg;
    logic [16:0]        demand_reg;
    logic [31:0]        prod_reg;
    logic [21:0]        scaled_reg;
    logic [16:0]        tphase_reg;
    logic [20:0]        blim_reg;

    logic               out_valid_reg;
    logic [17:0]        out_reg;
    logic [17:0]        res_reg;

    logic                      div_done;
    logic [DIV_DIVIDEND_W-1:0] div_quo;
    logic [DIV_DIVIDEND_W-1:0] div_dividend;
    logic [DIV_DIVISOR_W-1:0]  div_divisor;

    logic               in_window;
    logic               full_band;
    logic [16:0]        taper_fixed;
    logic [7:0]         taper_diff;
    logic [29:0]        taper_prod;
    logic [15:0]        tgt_batt;
    logic [33:0]        demand_full;
    logic [32:0]        gear_full;
    logic [38:0]        scale_full;
    logic [44:0]        phase_prod;
    logic [16:0]        support_now;
    logic [16:0]        duty_abs;
    logic [17:0]        out_next;

    eacc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vmax_reg <= 16'(MAX_SPEED_RESET);
            mmax_reg <= '0;
            mfb_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAX_SPEED:      vmax_reg <= cfg_data[15:0];
                REG_MOTOR_MAX:      mmax_reg <= $signed(cfg_data);
                REG_MOTOR_FALLBACK: mfb_reg  <= $signed(cfg_data);
                default:            ;
            endcase
        end
    end

    always_comb begin
        support_now = '0;
        if (drive_enable) begin
            case (assist_source)
                MODE_PAS:    support_now = pedaling ? 17'(UNITY_Q16) : 17'd0;
                MODE_TORQUE: support_now = torque_active ? {1'b0, torque_level} : 17'd0;
                default:     support_now = '0;
            endcase
        end
        duty_abs = duty_now[15] ? 17'(-{duty_now[15], duty_now}) : {1'b0, duty_now};
        if (duty_abs < 17'(DUTY_FLOOR_Q15)) begin
            duty_abs = 17'(DUTY_FLOOR_Q15);
        end
    end

    // speed taper
    always_comb begin
        full_band   = (vmax_reg >= 16'(TAPER_WINDOW))
                      && (speed_reg <= vmax_reg - 16'(TAPER_WINDOW));
        in_window   = !mtn_reg && (vmax_reg != 16'd0) && (speed_reg < vmax_reg) && !full_band;
        taper_diff  = 8'(vmax_reg - speed_reg);
        if (mtn_reg || (full_band && vmax_reg != 16'd0 && speed_reg < vmax_reg)) begin
            taper_fixed = 17'(UNITY_Q16);
        end else begin
            taper_fixed = '0;
        end
    end

    assign taper_prod  = taper_diff * 22'(TAPER_RECIP);
    assign tgt_batt    = prod_reg[31:16];
    assign demand_full = support_reg * taper_reg;
    assign gear_full   = gear_ma_reg * demand_reg;
    assign scale_full  = prod_reg * 7'(PHASE_RATIO_MUL);
    assign phase_prod  = scaled_reg * 23'(PHASE_RECIP);

    always_comb begin
        case (cmd.op)
            OP_DIV_BLIM:
            begin
                div_dividend = {1'b0, tgt_batt, 15'd0};
                div_divisor  = duty_mag_reg;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = 16'd1;
            end
        endcase
    end

    // phase target limits and slew
    always_comb begin
        logic signed [22:0] t;
        logic signed [22:0] meas_eff;
        logic signed [22:0] over;
        logic signed [22:0] corr;
        logic signed [22:0] maxc;
        logic signed [22:0] cur;
        logic signed [22:0] delta;
        logic signed [22:0] lim;
        logic signed [22:0] nxt;
        t    = $signed({6'd0, tphase_reg});
        cur  = $signed({5'd0, out_reg});
        meas_eff = $signed({{4{meas_reg[18]}}, meas_reg});
        if (meas_eff < 0) begin
            meas_eff = '0;
        end
        over = meas_eff - $signed({7'd0, tgt_batt});
        corr = cur - (over <<< 1);
        if (tgt_batt != 16'd0) begin
            if ($signed({2'd0, blim_reg}) < t) begin
                t = $signed({2'd0, blim_reg});
            end
            if (over > 0 && corr < t) begin
                t = corr;
            end
        end
        if (mmax_reg > 0) begin
            maxc = $signed({{4{mmax_reg[18]}}, mmax_reg});
        end else begin
            maxc = $signed({{4{mfb_reg[18]}}, mfb_reg});
        end
        if (maxc < 0) begin
            maxc = '0;
        end
        if (t > maxc) begin
            t = maxc;
        end
        if (t < 0) begin
            t = '0;
        end
        delta = t - cur;
        lim   = fast_up_reg ? 23'(RAMP_FAST_MA) : 23'(RAMP_SLOW_MA);
        if (delta < 0) begin
            lim = (tgt_batt == 16'd0) ? 23'(RAMP_FAST_MA) : 23'(RAMP_SLOW_MA);
        end
        if (delta > lim) begin
            delta = lim;
        end
        if (delta < -lim) begin
            delta = -lim;
        end
        nxt = cur + delta;
        if (nxt > maxc) begin
            nxt = maxc;
        end
        if (nxt < 0) begin
            nxt = '0;
        end
        out_next = stop_reg ? 18'd0 : nxt[17:0];
    end

    always_ff @(posedge clk) begin
        case (cmd.op)
            OP_LOAD:
            begin
                gear_ma_reg  <= gear_table(mountain_mode, gear);
                mtn_reg      <= mountain_mode;
                support_reg  <= support_now;
                fast_up_reg  <= (assist_source == MODE_TORQUE);
                speed_reg    <= speed_centikph;
                duty_mag_reg <= duty_abs[15:0];
                meas_reg     <= battery_current_valid ? battery_current_ma : 19'd0;
                stop_reg     <= stop;
            end
            OP_TAPER_FIXED: taper_reg  <= taper_fixed;
            OP_TAPER_WIN:   taper_reg  <= taper_prod[TAPER_RECIP_SHIFT+16:TAPER_RECIP_SHIFT];
            OP_DEMAND:
            begin
                if (demand_full[33:16] > 18'(UNITY_Q16)) begin
                    demand_reg <= 17'(UNITY_Q16);
                end else begin
                    demand_reg <= demand_full[32:16];
                end
            end
            OP_GEAR:        prod_reg   <= gear_full[31:0];
            OP_SCALE:       scaled_reg <= scale_full[37:16];
            OP_PHASE:       tphase_reg <= phase_prod[PHASE_RECIP_SHIFT+16:PHASE_RECIP_SHIFT];
            OP_BLIM_Q:      blim_reg   <= div_quo[20:0];
            OP_FINISH:      res_reg    <= out_next;
            default:        ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_FINISH) begin
                out_reg       <= out_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.taper_window = in_window;
    assign stat.batt_pos     = (tgt_batt != 16'd0);
    assign stat.div_done     = div_done;
    assign stat.out_free     = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign phase_current_ma = res_reg;

endmodule
`default_nettype wire

>>> hdl/ebike_assist_current_command.sv
// Top level: assist phase current command per service tick.
//
// One item in gives one phase current command out. When the battery
// current target is non-zero, the battery limit over duty also runs
// through a divider that yields two quotient bits a cycle, with a start
// step, the busy steps and a step to take the quotient. Speed taper and
// phase ratio use reciprocal multiplies. A new item is taken once the
// previous one has finished its work; a finished result waits in its own
// register until taken, and the next item's last step stalls while it
// waits. Configuration writes are accepted every cycle and must happen
// only while idle.
`default_nettype none
module ebike_assist_current_command
    import eacc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [18:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         gear,
    input  wire logic               mountain_mode,
    input  wire logic               drive_enable,
    input  wire logic [1:0]         assist_source,
    input  wire logic               pedaling,
    input  wire logic               torque_active,
    input  wire logic [15:0]        torque_level,
    input  wire logic [15:0]        speed_centikph,
    input  wire logic signed [15:0] duty_now,
    input  wire logic signed [18:0] battery_current_ma,
    input  wire logic               battery_current_valid,
    input  wire logic               stop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [17:0]             phase_current_ma
);

    dp_cmd_t    cmd;
    dp_status_t stat;

    eacc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    eacc_dp u_dp (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .stat                  (stat),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .gear                  (gear),
        .mountain_mode         (mountain_mode),
        .drive_enable          (drive_enable),
        .assist_source         (assist_source),
        .pedaling              (pedaling),
        .torque_active         (torque_active),
        .torque_level          (torque_level),
        .speed_centikph        (speed_centikph),
        .duty_now              (duty_now),
        .battery_current_ma    (battery_current_ma),
        .battery_current_valid (battery_current_valid),
        .stop                  (stop),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .phase_current_ma      (phase_current_ma)
    );

endmodule
`default_nettype wire

>>> verif/ebike_assist_current_command_test.sv
// Self-checking testbench for the e-bike assist phase current command block.
`timescale 1ns / 1ps

module ebike_assist_current_command_test
    import eacc_pkg::*;
();

    localparam longint UNITY      = 65536;
    localparam longint WINDOW     = 200;
    localparam longint DUTY_MIN   = 655;
    localparam longint SLEW_SLOW  = 4000;
    localparam longint SLEW_FAST  = 8000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES  = 80;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int CYCLE_LIMIT    = 1000000;

    typedef struct packed {
        logic [7:0]  gear;
        logic        mountain;
        logic        enabled;
        logic [1:0]  mode;
        logic        pedaling;
        logic        tq_active;
        logic [15:0] tq_level;
        logic [15:0] speed;
        logic [15:0] duty;
        logic [18:0] batt;
        logic        batt_valid;
        logic        stop;
    } tick_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [18:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  gear = '0;
    logic        mountain_mode = 1'b0;
    logic        drive_enable = 1'b0;
    logic [1:0]  assist_source = '0;
    logic        pedaling = 1'b0;
    logic        torque_active = 1'b0;
    logic [15:0] torque_level = '0;
    logic [15:0] speed_centikph = '0;
    logic signed [15:0] duty_now = '0;
    logic signed [18:0] battery_current_ma = '0;
    logic        battery_current_valid = 1'b0;
    logic        stop = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [17:0] phase_current_ma;

    // predictor state and register copies
    logic [15:0]        cfg_speed = 16'd2500;
    logic signed [18:0] cfg_motor_max = '0;
    logic signed [18:0] cfg_fallback = '0;
    longint             kept_ma = 0;

    tick_t       tick_q[$];
    logic [17:0] phase_cmd_q[$];
    tick_t       held;
    int          in_gap = 0, in_calm = 0, out_stall = 0, out_calm = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    ebike_assist_current_command i_dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .in_valid              (in_valid),
        .in_ready              (in_ready),
        .gear                  (gear),
        .mountain_mode         (mountain_mode),
        .drive_enable          (drive_enable),
        .assist_source         (assist_source),
        .pedaling              (pedaling),
        .torque_active         (torque_active),
        .torque_level          (torque_level),
        .speed_centikph        (speed_centikph),
        .duty_now              (duty_now),
        .battery_current_ma    (battery_current_ma),
        .battery_current_valid (battery_current_valid),
        .stop                  (stop),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .phase_current_ma      (phase_current_ma)
    );

    always #2 clk = ~clk;

    function automatic logic [17:0] next_phase_command(input tick_t t);
        longint gear_ma, support, taper, demand, tgt_batt, tgt_phase;
        longint maxc, delta, lim, mag, blim, over, corr, meas, vmax, spd;
        if (t.stop)
        begin
            kept_ma = 0;
            return '0;
        end
        if (t.mountain)
        begin
            case (t.gear)
                8'd0:    gear_ma = 0;
                8'd1:    gear_ma = 2500;
                8'd2:    gear_ma = 5000;
                8'd3:    gear_ma = 9000;
                8'd4:    gear_ma = 15000;
                8'd5:    gear_ma = 30000;
                default: gear_ma = 40000;
            endcase
        end
        else
        begin
            case (t.gear)
                8'd0:    gear_ma = 0;
                8'd1:    gear_ma = 2000;
                8'd2:    gear_ma = 3125;
                default: gear_ma = 5000;
            endcase
        end

        support = 0;
        if (t.enabled)
        begin
            if (t.mode == MODE_PAS)
                support = t.pedaling ? UNITY : 0;
            else if (t.mode == MODE_TORQUE)
                support = t.tq_active ? longint'(t.tq_level) : 0;
        end

        vmax = longint'(cfg_speed);
        spd = longint'(t.speed);
        if (t.mountain)
            taper = UNITY;
        else if (vmax == 0 || spd >= vmax)
            taper = 0;
        else if (spd <= vmax - WINDOW)
            taper = UNITY;
        else
        begin
            taper = (vmax - spd) * UNITY / WINDOW;
            if (taper > UNITY)
                taper = UNITY;
        end

        demand = (support * taper) >>> 16;
        if (demand > UNITY)
            demand = UNITY;
        tgt_batt = (gear_ma * demand) >>> 16;
        tgt_phase = (gear_ma * demand * 100) / (33 * UNITY);

        if (tgt_batt > 0)
        begin
            mag = longint'($signed(t.duty));
            if (mag < 0)
                mag = -mag;
            if (mag < DUTY_MIN)
                mag = DUTY_MIN;
            blim = (tgt_batt * 32768) / mag;
            if (blim < tgt_phase)
                tgt_phase = blim;
            meas = longint'($signed(t.batt));
            if (!t.batt_valid || meas < 0)
                meas = 0;
            over = meas - tgt_batt;
            if (over > 0)
            begin
                corr = kept_ma - 2 * over;
                if (corr < tgt_phase)
                    tgt_phase = corr;
            end
        end

        maxc = longint'(cfg_motor_max);
        if (maxc <= 0)
            maxc = longint'(cfg_fallback);
        if (maxc < 0)
            maxc = 0;
        if (tgt_phase > maxc)
            tgt_phase = maxc;
        if (tgt_phase < 0)
            tgt_phase = 0;

        delta = tgt_phase - kept_ma;
        lim = (t.mode == MODE_TORQUE) ? SLEW_FAST : SLEW_SLOW;
        if (delta < 0)
            lim = (tgt_batt <= 0) ? SLEW_FAST : SLEW_SLOW;
        if (delta > lim)
            delta = lim;
        if (delta < -lim)
            delta = -lim;

        kept_ma = kept_ma + delta;
        if (kept_ma > maxc)
            kept_ma = maxc;
        if (kept_ma < 0)
            kept_ma = 0;
        kept_ma = kept_ma & 64'h3FFFF;
        return kept_ma[17:0];
    endfunction

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        int r, lo, hi, v;
        t = '0;
        t.gear = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        t.mountain = 1'($urandom_range(0, 1));
        t.enabled = ($urandom_range(0, 99) < 92);
        r = $urandom_range(0, 99);
        if (r < 45)
            t.mode = MODE_PAS;
        else if (r < 85)
            t.mode = MODE_TORQUE;
        else if (r < 93)
            t.mode = MODE_HYBRID;
        else
            t.mode = MODE_UNUSED;
        t.pedaling = ($urandom_range(0, 99) < 85);
        t.tq_active = ($urandom_range(0, 99) < 85);
        t.tq_level = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 30 || cfg_speed == 0)
            t.speed = 16'($urandom);
        else if (r < 60)
            t.speed = 16'($urandom_range(0, int'(cfg_speed)));
        else
        begin
            lo = int'(cfg_speed) - 250;
            hi = int'(cfg_speed) + 50;
            if (lo < 0)
                lo = 0;
            if (hi > 65535)
                hi = 65535;
            t.speed = 16'($urandom_range(lo, hi));
        end
        if ($urandom_range(0, 99) < 15)
        begin
            v = int'($urandom_range(0, 1400)) - 700;
            t.duty = v[15:0];
        end
        else
            t.duty = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 60)
            v = $urandom_range(0, 8000);
        else if (r < 90)
            v = int'($urandom_range(0, 400000)) - 200000;
        else
            v = $urandom;
        t.batt = v[18:0];
        t.batt_valid = ($urandom_range(0, 99) < 90);
        t.stop = ($urandom_range(0, 99) < 4);
        return t;
    endfunction

    task automatic report_mismatch(input string what, input logic [17:0] got,
                                   input logic [17:0] want);
        $display("mismatch at cycle %0d: %s, got %0d expected %0d",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [18:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MAX_SPEED:      cfg_speed = val[15:0];
            REG_MOTOR_MAX:      cfg_motor_max = val;
            REG_MOTOR_FALLBACK: cfg_fallback = val;
            default:            ;
        endcase
    endtask

    task automatic wait_idle();
        while (tick_q.size() != 0 || in_valid || phase_cmd_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // item driver
    always @(posedge clk)
    begin : drive_proc
        logic  load;
        tick_t t;
        if (rst_n)
        begin
            load = !in_valid;
            if (in_valid && in_ready)
            begin
                phase_cmd_q.push_back(next_phase_command(held));
                load = 1'b1;
            end
            if (load)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (tick_q.size() > 0)
                begin
                    t = tick_q.pop_front();
                    held <= t;
                    gear <= t.gear;
                    mountain_mode <= t.mountain;
                    drive_enable <= t.enabled;
                    assist_source <= t.mode;
                    pedaling <= t.pedaling;
                    torque_active <= t.tq_active;
                    torque_level <= t.tq_level;
                    speed_centikph <= t.speed;
                    duty_now <= t.duty;
                    battery_current_ma <= t.batt;
                    battery_current_valid <= t.batt_valid;
                    stop <= t.stop;
                    in_valid <= 1'b1;
                    in_gap = pick_gap(in_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : watch_proc
        logic [17:0] want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (phase_cmd_q.size() == 0)
                    report_mismatch("result with no item pending", phase_current_ma, '0);
                else
                begin
                    want = phase_cmd_q.pop_front();
                    if (phase_current_ma !== want)
                        report_mismatch("phase_current_ma", phase_current_ma, want);
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                out_stall = pick_gap(out_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL ebike_assist_current_command");
            $finish;
        end
    end

    initial
    begin : stim_proc
        tick_t t, base;
        int ph, v;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(REG_MAX_SPEED, 19'd2500);
        write_reg(REG_MOTOR_MAX, 19'sd200000);
        write_reg(REG_MOTOR_FALLBACK, 19'd0);

        base = '0;
        base.gear = 8'd3;
        base.enabled = 1'b1;
        base.mode = MODE_PAS;
        base.pedaling = 1'b1;
        base.tq_active = 1'b1;
        base.tq_level = 16'd32768;
        base.speed = 16'd1000;
        base.duty = 16'd16384;
        base.batt = 19'd1000;
        base.batt_valid = 1'b1;

        t = base; t.gear = 8'd0; tick_q.push_back(t);
        t = base; tick_q.push_back(t);
        t = base; t.gear = 8'hFF; tick_q.push_back(t);
        t = base; t.mountain = 1'b1; t.gear = 8'hFF; t.speed = 16'hFFFF; tick_q.push_back(t);
        t = base; t.mountain = 1'b1; t.gear = 8'd6; t.duty = 16'd0; tick_q.push_back(t);
        t = base; t.mountain = 1'b1; t.gear = 8'd6; t.duty = 16'h8000; tick_q.push_back(t);
        t = base; t.mountain = 1'b1; t.gear = 8'd6; t.duty = 16'h7FFF;
        t.mode = MODE_TORQUE; t.tq_level = 16'hFFFF; tick_q.push_back(t);
        t = base; t.mountain = 1'b1; t.gear = 8'd6; t.duty = 16'h7FFF;
        t.mode = MODE_TORQUE; t.tq_level = 16'hFFFF; tick_q.push_back(t);
        // overcurrent pulls the output back from a high level
        t = base; t.mountain = 1'b1; t.gear = 8'd6; t.duty = 16'h7FFF;
        t.batt = 19'sd200000; tick_q.push_back(t);
        t = base; t.mode = MODE_TORQUE; t.tq_level = 16'd0; tick_q.push_back(t);
        t = base; t.mode = MODE_TORQUE; t.tq_active = 1'b0; tick_q.push_back(t);
        t = base; t.mode = MODE_HYBRID; tick_q.push_back(t);
        t = base; t.mode = MODE_UNUSED; tick_q.push_back(t);
        t = base; t.enabled = 1'b0; tick_q.push_back(t);
        t = base; t.pedaling = 1'b0; tick_q.push_back(t);
        t = base; t.speed = 16'd2500; tick_q.push_back(t);
        t = base; t.speed = 16'd2300; tick_q.push_back(t);
        t = base; t.speed = 16'd2450; tick_q.push_back(t);
        t = base; t.speed = 16'hFFFF; tick_q.push_back(t);
        t = base; t.duty = 16'd654; t.batt_valid = 1'b0; t.batt = 19'sd150000; tick_q.push_back(t);
        t = base; t.batt = -19'sd200000; tick_q.push_back(t);
        t = base; t.duty = 16'hFFFF; t.batt = 19'h7FFFF; tick_q.push_back(t);
        t = base; t.stop = 1'b1; tick_q.push_back(t);
        t = '1; tick_q.push_back(t);
        t = base; tick_q.push_back(t);

        for (ph = 1; ph <= 6; ph++)
        begin
            // wait until the block is idle and every result is back
            wait_idle();
            case (ph)
                1:
                begin
                    write_reg(REG_MOTOR_MAX, 19'd0);
                    write_reg(REG_MOTOR_FALLBACK, 19'sd150000);
                end
                2:
                begin
                    write_reg(REG_MAX_SPEED, 19'd0);
                    write_reg(REG_MOTOR_MAX, 19'sd200000);
                    write_reg(REG_MOTOR_FALLBACK, 19'd0);
                end
                3:
                begin
                    write_reg(REG_MAX_SPEED, 19'd65535);
                    write_reg(REG_MOTOR_MAX, -19'sd200000);
                    write_reg(REG_MOTOR_FALLBACK, -19'sd200000);
                end
                4:
                begin
                    write_reg(REG_MAX_SPEED, 19'd150);
                    write_reg(REG_MOTOR_MAX, 19'sd60000);
                    write_reg(REG_MOTOR_FALLBACK, 19'sd200000);
                end
                5:
                begin
                    v = $urandom_range(200, 6000);
                    write_reg(REG_MAX_SPEED, v[18:0]);
                    v = int'($urandom_range(0, 400000)) - 200000;
                    write_reg(REG_MOTOR_MAX, v[18:0]);
                    v = int'($urandom_range(0, 400000)) - 200000;
                    write_reg(REG_MOTOR_FALLBACK, v[18:0]);
                end
                default:
                begin
                    write_reg(REG_MAX_SPEED, 19'd3000);
                    write_reg(REG_MOTOR_FALLBACK, -19'sd5);
                    write_reg(REG_MOTOR_MAX, 19'sd200000);
                end
            endcase
            repeat (ITEMS_PER_PHASE) tick_q.push_back(random_tick());
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("PASS ebike_assist_current_command");
        else
            $display("FAIL ebike_assist_current_command");
        $finish;
    end

endmodule
